### rtl/wsfd_pkg.sv
`default_nettype none

package wsfd_pkg;

  // default width of the accepted payload length
  localparam int unsigned DEFAULT_PAYLOAD_LENGTH_BITS = 32;

  // opcodes of the frame header
  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // header sizes in bytes, key not included
  localparam logic [3:0] HDR_BASE  = 4'd2;
  localparam logic [3:0] HDR_EXT16 = 4'd4;
  localparam logic [3:0] HDR_EXT64 = 4'd10;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  typedef enum logic [2:0] {
    ST_PENDING = 3'd0,
    ST_OK      = 3'd1,
    ST_BADOP   = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_CTLCUT  = 3'd4,
    ST_LONG    = 3'd5
  } status_e;

  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_EXT  = 6'b000100,
    PH_KEY  = 6'b001000,
    PH_PAY  = 6'b010000,
    PH_SKIP = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        done_res;
    status_e     status;
    logic [3:0]  frame_opcode;
    logic [31:0] frame_payload_length;
    logic [32:0] consumed_length;
    logic        frame_masked;
  } out_beat_t;

endpackage

`default_nettype wire

### rtl/wsfd_chan_if.sv
`default_nettype none

interface wsfd_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/wsfd_parser.sv
`default_nettype none

module wsfd_parser #(
  parameter int unsigned PAYLOAD_LENGTH_BITS = wsfd_pkg::DEFAULT_PAYLOAD_LENGTH_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire wsfd_pkg::in_beat_t  beat_i,
  input  wire logic                payload_enable_i,
  output wsfd_pkg::out_beat_t      result_o
);
  import wsfd_pkg::*;

  localparam int unsigned POS_W     = PAYLOAD_LENGTH_BITS + 1;
  localparam int unsigned LEN_REG_W = (PAYLOAD_LENGTH_BITS > 32) ? PAYLOAD_LENGTH_BITS : 32;
  localparam int unsigned CMP_W     = (POS_W + 1 > LEN_REG_W + 1) ? POS_W + 1 : LEN_REG_W + 1;

  function automatic logic opcode_ok(input logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BIN ||
           op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  function automatic logic opcode_control(input logic [3:0] op);
    return op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  phase_e               phase_q, phase_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [3:0]           hl_q, hl_d;
  logic [LEN_REG_W-1:0] plen_q, plen_d;
  logic                 sticky_q, sticky_d;
  logic                 ovf_q, ovf_d;
  logic                 badop_q, badop_d;
  logic [31:0]          key_q, key_d;
  logic [3:0]           op_q, op_d;
  logic                 mask_q, mask_d;

  logic [CMP_W-1:0]     len;
  logic [3:0]           fh_now, fh_next;
  logic [CMP_W-1:0]     frame_end;
  logic [1:0]           key_idx;
  logic [7:0]           key_byte;

  // running length and header sizes
  assign len       = CMP_W'(pos_q) + CMP_W'(1);
  assign pos_d     = (&pos_q) ? pos_q : pos_q + POS_W'(1);
  assign fh_now    = hl_q + (mask_q ? KEY_BYTES : 4'd0);
  assign fh_next   = hl_d + (mask_d ? KEY_BYTES : 4'd0);
  assign frame_end = CMP_W'(fh_next) + CMP_W'(plen_d);

  // key byte for the current payload position
  assign key_idx = pos_q[1:0] - fh_now[1:0];
  always_comb begin
    unique case (key_idx)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // header parse and payload unmask for one byte
  always_comb begin
    logic [6:0] l7;
    l7       = beat_i.data_byte[6:0];
    phase_d  = phase_q;
    hl_d     = hl_q;
    plen_d   = plen_q;
    sticky_d = sticky_q;
    ovf_d    = ovf_q;
    badop_d  = badop_q;
    key_d    = key_q;
    op_d     = op_q;
    mask_d   = mask_q;
    result_o = '0;

    unique case (phase_q)
      PH_HDR0: begin
        op_d = beat_i.data_byte[3:0];
        if (opcode_ok(beat_i.data_byte[3:0])) begin
          phase_d = PH_HDR1;
        end else begin
          badop_d = 1'b1;
          phase_d = PH_SKIP;
        end
      end
      PH_HDR1: begin
        mask_d = beat_i.data_byte[7];
        if (l7 == LEN_EXT16) begin
          hl_d    = HDR_EXT16;
          phase_d = PH_EXT;
        end else if (l7 == LEN_EXT64) begin
          hl_d    = HDR_EXT64;
          phase_d = PH_EXT;
        end else begin
          hl_d   = HDR_BASE;
          plen_d = LEN_REG_W'(l7);
          if (beat_i.data_byte[7]) begin
            phase_d = PH_KEY;
          end else begin
            phase_d = (l7 == 7'd0) ? PH_SKIP : PH_PAY;
          end
        end
      end
      PH_EXT: begin
        sticky_d = sticky_q | (|plen_q[LEN_REG_W-1 -: 8]);
        plen_d   = {plen_q[LEN_REG_W-9:0], beat_i.data_byte};
        if (len == CMP_W'(hl_q)) begin
          if (sticky_d || (|(plen_d >> PAYLOAD_LENGTH_BITS))) begin
            ovf_d   = 1'b1;
            phase_d = PH_SKIP;
          end else if (mask_q) begin
            phase_d = PH_KEY;
          end else begin
            phase_d = (plen_d == '0) ? PH_SKIP : PH_PAY;
          end
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], beat_i.data_byte};
        if (len == CMP_W'(fh_now)) begin
          phase_d = (plen_q == '0) ? PH_SKIP : PH_PAY;
        end
      end
      PH_PAY: begin
        if (payload_enable_i) begin
          result_o.out_byte  = beat_i.data_byte ^ key_byte;
          result_o.out_valid = 1'b1;
        end
        if (len == frame_end) begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
      end
      default: begin
        phase_d = PH_SKIP;
      end
    endcase

    result_o.frame_opcode         = op_d;
    result_o.frame_payload_length = plen_d[31:0];
    result_o.frame_masked         = mask_d;
    result_o.done_res             = beat_i.last_byte;
    result_o.status               = ST_PENDING;

    // verdict on the segment's last byte
    if (beat_i.last_byte) begin
      priority if (len <= CMP_W'(2)) begin
        result_o.status = ST_TRUNC;
      end else if (badop_d) begin
        result_o.status = ST_BADOP;
      end else if (len <= CMP_W'(hl_d)) begin
        result_o.status = ST_TRUNC;
      end else if (ovf_d) begin
        result_o.status = ST_LONG;
      end else if (mask_d && len <= CMP_W'(fh_next)) begin
        if (opcode_control(op_d)) begin
          result_o.status          = ST_CTLCUT;
          result_o.consumed_length = 33'(hl_d);
        end else begin
          result_o.status = ST_TRUNC;
        end
      end else if (len < frame_end) begin
        result_o.status = ST_TRUNC;
      end else begin
        result_o.status          = ST_OK;
        result_o.consumed_length = frame_end[32:0];
      end
    end
  end

  // segment state, back to reset after each last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      pos_q    <= '0;
      hl_q     <= HDR_BASE;
      plen_q   <= '0;
      sticky_q <= 1'b0;
      ovf_q    <= 1'b0;
      badop_q  <= 1'b0;
      key_q    <= '0;
      op_q     <= '0;
      mask_q   <= 1'b0;
    end else if (step_i) begin
      if (beat_i.last_byte) begin
        phase_q  <= PH_HDR0;
        pos_q    <= '0;
        hl_q     <= HDR_BASE;
        plen_q   <= '0;
        sticky_q <= 1'b0;
        ovf_q    <= 1'b0;
        badop_q  <= 1'b0;
        key_q    <= '0;
        op_q     <= '0;
        mask_q   <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        hl_q     <= hl_d;
        plen_q   <= plen_d;
        sticky_q <= sticky_d;
        ovf_q    <= ovf_d;
        badop_q  <= badop_d;
        key_q    <= key_d;
        op_q     <= op_d;
        mask_q   <= mask_d;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/websocket_frame_decoder_unit.sv
// WebSocket frame decoder: parses the frame at the start of each segment and
// unmasks its payload.
//
// in_ch carries one segment byte per beat plus a last-byte flag. out_ch gives
// exactly one result beat per input beat: the unmasked payload byte when the
// byte is payload and payload output is on, the header fields seen so far,
// and on the segment's last byte the final status and consumed length.
// cfg_ch writes the one-bit payload enable; it is always ready and is meant
// to be written only while no beats are in flight.
//
// Throughput is one byte per clock while out_ch is ready. A beat accepted into
// the input register is parsed from it, and its result beat shows on out_ch
// from the result register: an input register, the parse and unmask
// logic, and a result register. The wide add and compare of header plus
// payload length against the byte count sits in that parse logic.
// Reset clears all segment state and sets payload enable to 1. When out_ch
// stalls, the result register and the input register both hold; in_ch drops
// ready once both are full and out_ch is not ready.
`default_nettype none

module websocket_frame_decoder_unit #(
  parameter int unsigned PAYLOAD_LENGTH_BITS = wsfd_pkg::DEFAULT_PAYLOAD_LENGTH_BITS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  wsfd_chan_if.sink    in_ch,
  wsfd_chan_if.source  out_ch,
  wsfd_chan_if.sink    cfg_ch
);
  import wsfd_pkg::*;

  logic      in_valid_q;
  in_beat_t  in_beat_q;
  logic      out_valid_q;
  out_beat_t out_beat_q;
  out_beat_t result;
  logic      enable_q;
  logic      step;

  // parse step moves the held beat into the result register
  assign step        = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || step;

  // configuration write
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      enable_q <= cfg_ch.payload;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_beat_q <= in_ch.payload;
    end
  end

  wsfd_parser #(
    .PAYLOAD_LENGTH_BITS(PAYLOAD_LENGTH_BITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .beat_i          (in_beat_q),
    .payload_enable_i(enable_q),
    .result_o        (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_beat_q <= result;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_beat_q;

  // a last byte always yields a final verdict in the next result beat
  a_last_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_beat_q.last_byte |=> out_valid_q && out_beat_q.done_res)
    else $error("last byte did not produce a done result");

  // status is pending exactly on beats that are not the segment's last
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_beat_q.done_res == (out_beat_q.status != ST_PENDING)))
    else $error("status and done flag disagree");

  // a consumed length is reported only for an accepted frame or a cut control frame
  a_consumed_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_beat_q.consumed_length != '0) |->
      (out_beat_q.status == ST_OK || out_beat_q.status == ST_CTLCUT))
    else $error("consumed length on a failed frame");

endmodule

`default_nettype wire
